>>> rtl/core/psched_pkg.sv
// Shared types, command codes and defaults of the periodic task scheduler.
package psched_pkg;

	// Parameter defaults
	localparam int TASK_COUNT_DEF   = 8;
	localparam int DELAY_BITS_DEF   = 16;
	localparam int PENDING_BITS_DEF = 8;

	// Stream payload widths
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;

	// Command codes carried on s_tuser
	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_LOAD     = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	// Operation of the shared entry update unit
	typedef enum logic [1:0] {
		ALU_TICK,
		ALU_DISPATCH,
		ALU_LOAD
	} alu_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_READ,
		ST_EXEC,
		ST_FLUSH
	} state_t;

	// Control from the sequencer to the task table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_valid;
	} tbl_ctrl_t;

endpackage

>>> rtl/core/psched_alu.sv
// Shared entry update unit: tick, dispatch and load arithmetic for one entry.
module psched_alu #(
	parameter int DELAY_BITS   = psched_pkg::DELAY_BITS_DEF,
	parameter int PENDING_BITS = psched_pkg::PENDING_BITS_DEF
) (
	input  psched_pkg::alu_op_t      op,
	input  logic [DELAY_BITS-1:0]    cur_delay,
	input  logic [DELAY_BITS-1:0]    cur_period,
	input  logic [PENDING_BITS-1:0]  cur_pend,
	input  logic [15:0]              ld_period,
	input  logic [15:0]              ld_phase,
	output logic [DELAY_BITS-1:0]    nxt_delay,
	output logic [DELAY_BITS-1:0]    nxt_period,
	output logic [PENDING_BITS-1:0]  nxt_pend
);
	import psched_pkg::*;

	localparam logic [31:0] DELAY_MAX = 32'((64'd1 << DELAY_BITS) - 64'd1);
	localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};

	logic [31:0] per_c;
	logic [31:0] ph_c;

	// Saturate load values to the delay width
	always_comb begin
		per_c = (32'(ld_period) > DELAY_MAX) ? DELAY_MAX : 32'(ld_period);
		ph_c  = (32'(ld_phase) > DELAY_MAX) ? DELAY_MAX : 32'(ld_phase);
	end

	// Entry update
	always_comb begin
		nxt_delay  = cur_delay;
		nxt_period = cur_period;
		nxt_pend   = cur_pend;
		case (op)
			ALU_TICK: begin
				if (cur_delay != '0) begin
					nxt_delay = cur_delay - 1'b1;
				end else begin
					nxt_delay = cur_period - 1'b1;
					if (cur_pend != PEND_MAX) nxt_pend = cur_pend + 1'b1;
				end
			end
			ALU_DISPATCH: begin
				nxt_pend = cur_pend - 1'b1;
			end
			ALU_LOAD: begin
				nxt_period = (per_c == 32'd0) ? DELAY_BITS'(1) : DELAY_BITS'(per_c);
				nxt_delay  = DELAY_BITS'(ph_c);
				nxt_pend   = '0;
			end
			default: begin
				nxt_delay = cur_delay;
			end
		endcase
	end

endmodule

>>> rtl/core/psched_table.sv
// Task table: entry memory with registered read and per-entry valid flops.
module psched_table #(
	parameter int TASK_COUNT   = psched_pkg::TASK_COUNT_DEF,
	parameter int DELAY_BITS   = psched_pkg::DELAY_BITS_DEF,
	parameter int PENDING_BITS = psched_pkg::PENDING_BITS_DEF,
	localparam int IDX_BITS    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psched_pkg::tbl_ctrl_t    ctrl,
	input  logic [IDX_BITS-1:0]      addr,
	input  logic [DELAY_BITS-1:0]    wr_delay,
	input  logic [DELAY_BITS-1:0]    wr_period,
	input  logic [PENDING_BITS-1:0]  wr_pend,
	output logic                     rd_valid,
	output logic [DELAY_BITS-1:0]    rd_delay,
	output logic [DELAY_BITS-1:0]    rd_period,
	output logic [PENDING_BITS-1:0]  rd_pend
);
	import psched_pkg::*;

	logic [DELAY_BITS-1:0]   delay_mem  [TASK_COUNT];
	logic [DELAY_BITS-1:0]   period_mem [TASK_COUNT];
	logic [PENDING_BITS-1:0] pend_mem   [TASK_COUNT];
	logic [TASK_COUNT-1:0]   valid_q;

	// Entry memory: one write and one registered read per cycle, at the same address
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			delay_mem[addr]  <= wr_delay;
			period_mem[addr] <= wr_period;
			pend_mem[addr]   <= wr_pend;
		end
		if (ctrl.rd_en) begin
			rd_delay  <= delay_mem[addr];
			rd_period <= period_mem[addr];
			rd_pend   <= pend_mem[addr];
		end
	end

	// Valid flags, cleared at reset and set per entry by set_valid; rd_valid is registered with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (ctrl.set_valid) valid_q[addr] <= 1'b1;
			if (ctrl.rd_en) rd_valid <= valid_q[addr];
		end
	end

endmodule

>>> rtl/core/periodic_task_scheduler_unit.sv
// Top level of the periodic task scheduler: command sequencer and output register.
//
// Channel  Dir  Fields (low bit up)                                   Accept
// s_*      in   tuser: command[1:0]; tdata: entry_index[2:0],         s_tvalid & s_tready
//               entry_period[18:3], entry_phase[34:19]
// m_*      out  tdata: task_index[2:0]; tlast: last_of_run            m_tvalid & m_tready
//
// A tick or dispatch walks the table through the one memory port, reading and then
// updating each entry in turn (ST_READ, then ST_EXEC); a dispatch ends in ST_FLUSH,
// and a load writes its entry in ST_LOAD.
// A dispatch holds on a pending entry while one is held and the output is full, not taken.
// Reset clears all valid flags at once, no clearing pass; s_tready is high only
// while the sequencer is idle, and a result may still wait in the output register.
module periodic_task_scheduler_unit #(
	parameter int TASK_COUNT   = psched_pkg::TASK_COUNT_DEF,
	parameter int DELAY_BITS   = psched_pkg::DELAY_BITS_DEF,
	parameter int PENDING_BITS = psched_pkg::PENDING_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [psched_pkg::S_TDATA_W-1:0] s_tdata,  // entry_index, entry_period, entry_phase
	input  logic [psched_pkg::S_TUSER_W-1:0] s_tuser,  // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [psched_pkg::M_TDATA_W-1:0] m_tdata,  // task_index
	output logic                            m_tlast   // last_of_run
);
	import psched_pkg::*;

	localparam int IDX_BITS = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TASK_COUNT - 1);

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [IDX_BITS-1:0]  ld_idx_q;
	logic [15:0]          ld_period_q;
	logic [15:0]          ld_phase_q;
	logic                 held_valid_q;
	logic [IDX_BITS-1:0]  held_idx_q;
	logic                 out_valid_q;
	logic [2:0]           out_idx_q;
	logic                 out_last_q;

	tbl_ctrl_t              tctrl;
	logic [IDX_BITS-1:0]    taddr;
	logic                   rd_valid;
	logic [DELAY_BITS-1:0]  rd_delay, rd_period;
	logic [PENDING_BITS-1:0] rd_pend;
	alu_op_t                alu_op;
	logic [DELAY_BITS-1:0]  nxt_delay, nxt_period;
	logic [PENDING_BITS-1:0] nxt_pend;

	logic s_acc;
	logic in_range;
	logic out_free;
	logic push, push_last, hold_set, hold_clr, idx_step;
	logic [IDX_BITS-1:0] push_idx;

	assign s_acc    = s_tvalid && s_tready;
	assign in_range = 32'(s_tdata[2:0]) < TASK_COUNT;
	assign out_free = !out_valid_q || m_tready;
	assign taddr    = (state_q == ST_LOAD) ? ld_idx_q : idx_q;

	// Shared update unit
	psched_alu #(
		.DELAY_BITS   (DELAY_BITS),
		.PENDING_BITS (PENDING_BITS)
	) u_alu (
		.op         (alu_op),
		.cur_delay  (rd_delay),
		.cur_period (rd_period),
		.cur_pend   (rd_pend),
		.ld_period  (ld_period_q),
		.ld_phase   (ld_phase_q),
		.nxt_delay  (nxt_delay),
		.nxt_period (nxt_period),
		.nxt_pend   (nxt_pend)
	);

	// Task table
	psched_table #(
		.TASK_COUNT   (TASK_COUNT),
		.DELAY_BITS   (DELAY_BITS),
		.PENDING_BITS (PENDING_BITS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (tctrl),
		.addr      (taddr),
		.wr_delay  (nxt_delay),
		.wr_period (nxt_period),
		.wr_pend   (nxt_pend),
		.rd_valid  (rd_valid),
		.rd_delay  (rd_delay),
		.rd_period (rd_period),
		.rd_pend   (rd_pend)
	);

	// Next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		tctrl     = '0;
		alu_op    = ALU_TICK;
		push      = 1'b0;
		push_last = 1'b0;
		push_idx  = held_idx_q;
		hold_set  = 1'b0;
		hold_clr  = 1'b0;
		idx_step  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (cmd_t'(s_tuser))
						CMD_TICK, CMD_DISPATCH: state_d = ST_READ;
						CMD_LOAD:               state_d = in_range ? ST_LOAD : ST_IDLE;
						default:                state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				alu_op          = ALU_LOAD;
				tctrl.wr_en     = 1'b1;
				tctrl.set_valid = 1'b1;
				state_d         = ST_IDLE;
			end
			ST_READ: begin
				tctrl.rd_en = 1'b1;
				state_d     = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd_q == CMD_TICK) begin
					alu_op      = ALU_TICK;
					tctrl.wr_en = rd_valid;
					idx_step    = 1'b1;
				end else begin
					alu_op = ALU_DISPATCH;
					if (rd_valid && rd_pend != '0) begin
						// Release the held index first; wait only if one is held and the output is blocked
						if (!held_valid_q || out_free) begin
							tctrl.wr_en = 1'b1;
							push        = held_valid_q;
							hold_set    = 1'b1;
							idx_step    = 1'b1;
						end
					end else begin
						idx_step = 1'b1;
					end
				end
				if (idx_step) begin
					if (idx_q == LAST_IDX) begin
						state_d = (cmd_q == CMD_DISPATCH) ? ST_FLUSH : ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_FLUSH: begin
				// Final released index carries the last flag
				if (!held_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					hold_clr  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= CMD_NONE;
			idx_q        <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				cmd_q <= cmd_t'(s_tuser);
				idx_q <= '0;
			end else if (idx_step && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
			if (hold_set) held_valid_q <= 1'b1;
			else if (hold_clr) held_valid_q <= 1'b0;
			if (push) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ld_idx_q    <= IDX_BITS'(s_tdata[2:0]);
			ld_period_q <= s_tdata[18:3];
			ld_phase_q  <= s_tdata[34:19];
		end
		if (hold_set) held_idx_q <= idx_q;
		if (push) begin
			out_idx_q  <= 3'(push_idx);
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(out_idx_q);
	assign m_tlast  = out_last_q;

endmodule

>>> bench/periodic_task_scheduler_unit_tb.sv
// Self-checking testbench for the periodic task scheduler: predicted task releases vs. stream output.
`timescale 1ns / 100ps

module periodic_task_scheduler_unit_tb;
	import psched_pkg::*;

	localparam int NTASK       = TASK_COUNT_DEF;
	localparam int DBITS       = DELAY_BITS_DEF;
	localparam int PBITS       = PENDING_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	// dispatch walk through read, update and flush states, plus output register slack
	localparam int DRAIN_CYCLES = 2 * NTASK + 1 + 24;

	// One released task as it should appear on the master side
	typedef struct {
		logic [2:0] task_index;
		logic       last_of_run;
	} release_t;

	// Scheduler table model plus queue of releases still to come
	class release_tracker;
		logic [DBITS-1:0] delay_tbl[NTASK];
		logic [DBITS-1:0] period_tbl[NTASK];
		logic [PBITS-1:0] pend_tbl[NTASK];
		logic             valid_tbl[NTASK];
		release_t         expected_releases[$];
		int               mismatches;
		int               releases_seen;
		int               saturated_ticks;
		int               max_run;

		function new();
			for (int i = 0; i < NTASK; i++) begin
				delay_tbl[i]  = '0;
				period_tbl[i] = DBITS'(1);
				pend_tbl[i]   = '0;
				valid_tbl[i]  = 1'b0;
			end
			mismatches      = 0;
			releases_seen   = 0;
			saturated_ticks = 0;
			max_run         = 0;
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			mismatches++;
		endtask

		function int outstanding();
			return expected_releases.size();
		endfunction

		// Apply one accepted command to the table and queue the releases it causes
		function void note_command(cmd_t cmd, logic [2:0] idx, logic [15:0] per,
				logic [15:0] ph);
			release_t rel;
			int       first_q;
			first_q = expected_releases.size();
			case (cmd)
				CMD_TICK: begin
					for (int i = 0; i < NTASK; i++) begin
						if (valid_tbl[i]) begin
							if (delay_tbl[i] != '0) begin
								delay_tbl[i] = delay_tbl[i] - 1'b1;
							end else begin
								if (pend_tbl[i] != '1)
									pend_tbl[i] = pend_tbl[i] + 1'b1;
								else
									saturated_ticks++;
								delay_tbl[i] = period_tbl[i] - 1'b1;
							end
						end
					end
				end
				CMD_DISPATCH: begin
					for (int i = 0; i < NTASK; i++) begin
						if (valid_tbl[i] && pend_tbl[i] != '0) begin
							rel.task_index  = i[2:0];
							rel.last_of_run = 1'b0;
							expected_releases.push_back(rel);
							pend_tbl[i] = pend_tbl[i] - 1'b1;
						end
					end
					if (expected_releases.size() > first_q)
						expected_releases[expected_releases.size() - 1].last_of_run = 1'b1;
					if (expected_releases.size() - first_q > max_run)
						max_run = expected_releases.size() - first_q;
				end
				CMD_LOAD: begin
					if (idx < NTASK) begin
						period_tbl[idx] = (per == '0) ? DBITS'(1) : per;
						delay_tbl[idx]  = ph;
						pend_tbl[idx]   = '0;
						valid_tbl[idx]  = 1'b1;
					end
				end
				default: ;  // unused command: no effect
			endcase
		endfunction

		// Compare one accepted output transaction with the oldest expected release
		task check_release(logic [M_TDATA_W-1:0] tdata, logic tlast);
			release_t rel;
			releases_seen++;
			if (expected_releases.size() == 0) begin
				report_mismatch($sformatf("unexpected release idx=%0d last=%0b",
					tdata[2:0], tlast));
			end else begin
				rel = expected_releases.pop_front();
				if (tdata[2:0] !== rel.task_index)
					report_mismatch($sformatf("task_index got %0d want %0d",
						tdata[2:0], rel.task_index));
				if (tdata[M_TDATA_W-1:3] !== '0)
					report_mismatch($sformatf("m_tdata padding not zero: %h", tdata));
				if (tlast !== rel.last_of_run)
					report_mismatch($sformatf("last_of_run got %0b want %0b (idx %0d)",
						tlast, rel.last_of_run, rel.task_index));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	release_tracker board = new();
	int cycle_count = 0;
	int burst_left  = 0;
	int cmd_counts[4] = '{0, 0, 0, 0};

	periodic_task_scheduler_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d releases outstanding",
				cycle_count, board.outstanding());
			$display("** periodic_task_scheduler_unit: FAILED **");
			$finish;
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_release(m_tdata, m_tlast);
	end

	// Receiver backpressure: ready runs broken by stalls of varying length
	initial begin
		int run;
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			run   = $urandom_range(1, 24);
			stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) :
				$urandom_range(0, 3);
			repeat (run) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	// Load payload: index, period, phase from the low bit up
	function automatic logic [S_TDATA_W-1:0] pack_entry(logic [2:0] idx, logic [15:0] per,
			logic [15:0] ph);
		return {5'b0, ph, per, idx};
	endfunction

	// Payload filler for commands that ignore tdata
	function automatic logic [S_TDATA_W-1:0] noise_payload();
		logic [2:0]  hi;
		logic [31:0] lo;
		hi = 3'($urandom_range(0, 7));
		lo = $urandom();
		return {5'b0, hi, lo};
	endfunction

	// Send one command transaction, then apply the burst/gap pacing
	task automatic issue(cmd_t cmd, logic [S_TDATA_W-1:0] data);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		board.note_command(cmd, data[2:0], data[18:3], data[34:19]);
		cmd_counts[cmd]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 8);
		end
	endtask

	task automatic issue_load(logic [2:0] idx, logic [15:0] per, logic [15:0] ph);
		issue(CMD_LOAD, pack_entry(idx, per, ph));
	endtask

	// Stimulus
	initial begin
		int         pick;
		logic [2:0] idx;
		logic [15:0] per;
		logic [15:0] ph;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_TICK;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, unused command, field extremes
		issue(CMD_DISPATCH, '0);
		issue(CMD_TICK, noise_payload());
		issue(CMD_NONE, {5'b0, {35{1'b1}}});
		issue(CMD_NONE, '0);
		issue_load(3'd0, 16'd0, 16'd0);          // period 0 clamps to 1
		issue_load(3'd7, 16'hFFFF, 16'hFFFF);
		issue_load(3'd3, 16'd2, 16'd1);
		issue_load(3'd5, 16'd1, 16'd0);
		issue(CMD_TICK, '0);
		issue(CMD_TICK, {5'b0, {35{1'b1}}});
		issue(CMD_DISPATCH, noise_payload());
		repeat (3) issue(CMD_TICK, noise_payload());
		issue_load(3'd5, 16'd3, 16'd0);          // reload drops pending runs
		issue(CMD_DISPATCH, '0);
		issue_load(3'd1, 16'd1, 16'd0);
		issue_load(3'd2, 16'd1, 16'd0);
		issue_load(3'd4, 16'd1, 16'd0);
		issue_load(3'd6, 16'd1, 16'd0);
		issue_load(3'd7, 16'd1, 16'd0);
		issue_load(3'd3, 16'd1, 16'd0);
		issue(CMD_TICK, '0);
		issue(CMD_DISPATCH, '0);                 // all eight entries release
		issue(CMD_DISPATCH, '0);

		// Saturate pending counts on period-1 entries, then drain a little
		repeat ((1 << PBITS) + 8) issue(CMD_TICK, noise_payload());
		issue(CMD_DISPATCH, '0);
		issue(CMD_DISPATCH, '0);

		// Random mix, biased toward short periods so releases are frequent
		repeat (210) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				issue(CMD_TICK, noise_payload());
			end else if (pick < 72) begin
				issue(CMD_DISPATCH, noise_payload());
			end else if (pick < 92) begin
				idx = 3'($urandom_range(0, 7));
				per = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) :
					16'($urandom_range(0, 65535));
				ph  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 8)) :
					16'($urandom_range(0, 65535));
				issue_load(idx, per, ph);
			end else begin
				issue(CMD_NONE, noise_payload());
			end
		end

		// Drain
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d ticks, %0d dispatches, %0d loads, %0d unused commands",
			cmd_counts[CMD_TICK], cmd_counts[CMD_DISPATCH], cmd_counts[CMD_LOAD],
			cmd_counts[CMD_NONE]);
		$display("%0d releases checked, longest dispatch %0d, %0d saturated ticks, %0d cycles",
			board.releases_seen, board.max_run, board.saturated_ticks, cycle_count);
		if (board.mismatches == 0) begin
			$display("** periodic_task_scheduler_unit: PASSED **");
		end else begin
			$display("** periodic_task_scheduler_unit: FAILED **");
		end
		$finish;
	end

endmodule

>>> periodic_task_scheduler_unit.f
rtl/core/psched_pkg.sv
rtl/core/psched_alu.sv
rtl/core/psched_table.sv
rtl/core/periodic_task_scheduler_unit.sv
bench/periodic_task_scheduler_unit_tb.sv
